### rtl/bdts_pkg.sv
// ----------------------------------------------------------------------------
// bdts_pkg
// Types, codes and BCD helpers shared by the date/time setter.
// ----------------------------------------------------------------------------
package bdts_pkg;

    typedef enum logic [2:0] {
        PH_YEAR  = 3'd0,
        PH_MDATE = 3'd1,
        PH_WDAY  = 3'd2,
        PH_HMIN  = 3'd3,
        PH_IDLE  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ACT_SET  = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2
    } t_action;

    // display tags for phases without a left-hand value
    localparam logic [7:0] SHOW_YEAR_TAG = 8'h20;
    localparam logic [7:0] SHOW_WDAY_TAG = 8'hAA;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] cur_year;
        logic [4:0] cur_month;
        logic [5:0] cur_date;
        logic [2:0] cur_weekday;
        logic [5:0] cur_hour;
        logic [6:0] cur_minute;
    } t_in;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] show_high;
        logic [7:0] show_low;
        logic       commit;
        logic [7:0] new_year;
        logic [4:0] new_month;
        logic [5:0] new_date;
        logic [2:0] new_weekday;
        logic [5:0] new_hour;
        logic [6:0] new_minute;
    } t_out;

    // edit registers bar weekday at byte width, so out-of-range BCD wraps as bytes
    typedef struct packed {
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] date;
        logic [2:0] weekday;
        logic [7:0] hour;
        logic [7:0] minute;
    } t_cal;

    localparam t_cal CAL_RESET = '{
        year: 8'h00, month: 8'h01, date: 8'h01, weekday: 3'd1, hour: 8'h00, minute: 8'h00
    };

    function automatic logic [7:0] bcd_inc(input logic [7:0] v);
        logic [7:0] t;
        t = v + 8'd1;
        if (t[3:0] == 4'hA) begin
            t = t + 8'd6;
        end
        return t;
    endfunction

    function automatic logic [7:0] bcd_dec(input logic [7:0] v);
        logic [7:0] t;
        t = v - 8'd1;
        if (t[3:0] == 4'hF) begin
            t = t - 8'd6;
        end
        return t;
    endfunction

    function automatic logic [7:0] month_up(input logic [7:0] m);
        logic [7:0] t;
        t = bcd_inc(m);
        if (t == 8'h13) begin
            t = 8'h01;
        end
        return t;
    endfunction

    function automatic logic has_thirty(input logic [7:0] m);
        return (m == 8'h04) || (m == 8'h06) || (m == 8'h09) || (m == 8'h11);
    endfunction

    // tens*10 + units is divisible by four iff (2*tens + units) mod 4 is zero
    function automatic logic is_leap(input logic [7:0] y);
        logic [1:0] s;
        s = {y[4], 1'b0} + y[1:0];
        return (s == 2'd0);
    endfunction

endpackage

### rtl/bdts_step.sv
// ----------------------------------------------------------------------------
// bdts_step
// Next edit phase, next calendar registers and the result item for one
// button event.
// ----------------------------------------------------------------------------
module bdts_step (
    input  bdts_pkg::t_in    i_item,
    input  bdts_pkg::t_cal   i_cal,
    input  bdts_pkg::t_phase i_phase,
    output bdts_pkg::t_cal   o_cal,
    output bdts_pkg::t_phase o_phase,
    output bdts_pkg::t_out   o_res
);
    import bdts_pkg::*;

    t_cal       cal;
    t_phase     ph;
    logic       commit;
    logic       leap;
    logic [7:0] d;
    logic [7:0] show_hi;
    logic [7:0] show_lo;

    assign leap = is_leap(i_cal.year);

    always_comb begin
        cal    = i_cal;
        ph     = i_phase;
        commit = 1'b0;
        d      = 8'h00;

        case (i_item.action)
            ACT_SET: begin
                case (i_phase)
                    PH_YEAR:  ph = PH_MDATE;
                    PH_MDATE: ph = PH_WDAY;
                    PH_WDAY:  ph = PH_HMIN;
                    PH_HMIN: begin
                        ph     = PH_IDLE;
                        commit = 1'b1;
                    end
                    default: begin
                        // entering the year phase takes a copy of the clock
                        ph          = PH_YEAR;
                        cal.year    = i_item.cur_year;
                        cal.month   = {3'd0, i_item.cur_month};
                        cal.date    = {2'd0, i_item.cur_date};
                        cal.weekday = i_item.cur_weekday;
                        cal.hour    = {2'd0, i_item.cur_hour};
                        cal.minute  = {1'b0, i_item.cur_minute};
                    end
                endcase
            end
            ACT_UP: begin
                case (i_phase)
                    PH_YEAR: begin
                        cal.year = bcd_inc(i_cal.year);
                        if (cal.year == 8'hA0) begin
                            cal.year = 8'h00;
                        end
                    end
                    PH_MDATE: begin
                        d = i_cal.date + 8'd1;
                        if (i_cal.month == 8'h02 &&
                            ((leap && d == 8'h2A) || (!leap && d == 8'h29))) begin
                            cal.month = month_up(i_cal.month);
                            d         = 8'h01;
                        end else if (d[3:0] == 4'hA) begin
                            d = d + 8'd6;
                        end else if (d > 8'h30) begin
                            if (d == 8'h32 || has_thirty(i_cal.month)) begin
                                cal.month = month_up(i_cal.month);
                                d         = 8'h01;
                            end
                        end
                        cal.date = d;
                    end
                    PH_WDAY: begin
                        cal.weekday = (i_cal.weekday == 3'd7 || i_cal.weekday == 3'd0) ?
                                      3'd1 : i_cal.weekday + 3'd1;
                    end
                    PH_HMIN: begin
                        cal.minute = bcd_inc(i_cal.minute);
                        if (cal.minute == 8'h60) begin
                            cal.minute = 8'h00;
                            cal.hour   = (i_cal.hour == 8'h23) ? 8'h00 : bcd_inc(i_cal.hour);
                        end
                    end
                    default: ;
                endcase
            end
            ACT_DOWN: begin
                case (i_phase)
                    PH_YEAR: begin
                        cal.year = bcd_dec(i_cal.year);
                        if (cal.year == 8'hF9) begin
                            cal.year = 8'h99;
                        end
                    end
                    PH_MDATE: begin
                        d = bcd_dec(i_cal.date);
                        if (d == 8'h00) begin
                            cal.month = (i_cal.month <= 8'h01) ? 8'h12 : bcd_dec(i_cal.month);
                            if (cal.month == 8'h02) begin
                                d = leap ? 8'h29 : 8'h28;
                            end else if (has_thirty(cal.month)) begin
                                d = 8'h30;
                            end else begin
                                d = 8'h31;
                            end
                        end
                        cal.date = d;
                    end
                    PH_WDAY: begin
                        cal.weekday = (i_cal.weekday <= 3'd1) ? 3'd7 : i_cal.weekday - 3'd1;
                    end
                    PH_HMIN: begin
                        cal.minute = bcd_dec(i_cal.minute);
                        if (cal.minute == 8'hF9) begin
                            cal.minute = 8'h59;
                            cal.hour   = bcd_dec(i_cal.hour);
                            if (cal.hour == 8'hF9) begin
                                cal.hour = 8'h23;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;  // unused action code: hold everything
        endcase
    end

    always_comb begin
        case (ph)
            PH_YEAR: begin
                show_hi = SHOW_YEAR_TAG;
                show_lo = cal.year;
            end
            PH_MDATE: begin
                show_hi = cal.month;
                show_lo = cal.date;
            end
            PH_WDAY: begin
                show_hi = SHOW_WDAY_TAG;
                show_lo = {5'd0, cal.weekday};
            end
            PH_HMIN: begin
                show_hi = cal.hour;
                show_lo = cal.minute;
            end
            default: begin
                show_hi = 8'h00;
                show_lo = 8'h00;
            end
        endcase
    end

    assign o_cal   = cal;
    assign o_phase = ph;

    assign o_res.phase       = ph;
    assign o_res.show_high   = show_hi;
    assign o_res.show_low    = show_lo;
    assign o_res.commit      = commit;
    assign o_res.new_year    = cal.year;
    assign o_res.new_month   = cal.month[4:0];
    assign o_res.new_date    = cal.date[5:0];
    assign o_res.new_weekday = cal.weekday;
    assign o_res.new_hour    = cal.hour[5:0];
    assign o_res.new_minute  = cal.minute[6:0];

endmodule

### rtl/bcd_date_time_setter.sv
// ----------------------------------------------------------------------------
// bcd_date_time_setter
// Set-time editor of a real-time clock with BCD calendar fields.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_data): one button event per
// transfer - setting, up or down - plus the current clock values, which are
// only used when the setting button leaves idle for the year phase.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one result
// per event: phase, the two display bytes, the commit flag (set on leaving
// hour/minute) and the edited calendar values.
// An event lands in the input register, passes the combinational update
// logic and sits in the result register, from which the output transfer
// is made. One event is taken per cycle unless the receiver stalls; the
// calendar registers are written as each event moves into the result
// register, so the next event sees them straight away.
// Reset puts the editor in idle with 00-01-01, weekday 1, 00:00, and empties
// both registers. When the receiver stalls the result holds; the input
// register still fills, then o_in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module bcd_date_time_setter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bdts_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bdts_pkg::t_out  o_out_data
);
    import bdts_pkg::*;

    logic   r_in_vld;
    t_in    r_in;
    logic   r_out_vld;
    t_out   r_out;
    t_cal   r_cal;
    t_phase r_phase;

    t_cal   n_cal;
    t_phase n_phase;
    t_out   n_res;
    logic   advance;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    bdts_step u_step (
        .i_item  (r_in),
        .i_cal   (r_cal),
        .i_phase (r_phase),
        .o_cal   (n_cal),
        .o_phase (n_phase),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_IDLE;
            r_cal     <= CAL_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_phase   <= n_phase;
                r_cal     <= n_cal;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // commit only ever comes with the return to idle
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.commit |-> o_out_data.phase == PH_IDLE)
        else $error("commit outside idle");

    // blank display in idle
    a_idle_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.phase == PH_IDLE |->
            o_out_data.show_high == 8'h00 && o_out_data.show_low == 8'h00)
        else $error("display not blank in idle");

    // result phase follows the phase register it was computed into
    a_phase_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_data.phase == r_phase)
        else $error("result phase differs from edit phase");

    // a result is never dropped while the receiver stalls
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result lost under stall");

endmodule
